// ===== design/lrcts_pkg.sv =====
// Shared types, character codes and time arithmetic for the lyric timestamp parser.
package lrcts_pkg;

	localparam int unsigned TIME_W = 26;
	localparam int unsigned ACC_W = 10;
	localparam logic [ACC_W-1:0] FIELD_MAX = 10'd999;

	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [3:0] {
		PH_BRACKET = 4'd0,
		PH_MIN = 4'd1,
		PH_SKIP_COL = 4'd2,
		PH_SEC = 4'd3,
		PH_SKIP_DOT = 4'd4,
		PH_FRAC = 4'd5,
		PH_SKIP_SPC = 4'd6,
		PH_FIRST = 4'd7,
		PH_TEXT = 4'd8,
		PH_DONE = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		EV_START = 3'd0,
		EV_TEXT = 3'd1,
		EV_LINE_END = 3'd2,
		EV_EMPTY = 3'd3,
		EV_LYR_END = 3'd4,
		EV_ERROR = 3'd5
	} event_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic text_end;
		logic restart;
	} item_t;

	typedef struct packed {
		logic valid;
		event_t ev;
		logic [31:0] start_ms;
		logic [7:0] char_out;
	} result_t;

	// Decimal accumulate with saturation at 999.
	function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] acc,
			input logic [3:0] digit);
		logic [13:0] v;
		v = {4'd0, acc} * 14'd10 + {10'd0, digit};
		return (v > {4'd0, FIELD_MAX}) ? FIELD_MAX : v[ACC_W-1:0];
	endfunction

	// Line start time in milliseconds; the fraction is scaled by its digit count.
	function automatic logic [TIME_W-1:0] line_time(input logic [ACC_W-1:0] minutes,
			input logic [ACC_W-1:0] seconds, input logic [ACC_W-1:0] frac,
			input logic [1:0] digits);
		logic [TIME_W-1:0] f;
		case (digits)
			2'd1: f = TIME_W'(frac) * TIME_W'(100);
			2'd2: f = TIME_W'(frac) * TIME_W'(10);
			2'd3: f = TIME_W'(frac);
			default: f = '0;
		endcase
		return TIME_W'(minutes) * TIME_W'(60000) + TIME_W'(seconds) * TIME_W'(1000) + f;
	endfunction

endpackage

// ===== design/lrcts_parse.sv =====
// Header and text state machine of the lyric timestamp parser.
module lrcts_parse (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input lrcts_pkg::item_t item,
	output lrcts_pkg::result_t res
);

	lrcts_pkg::phase_t phase_q, phase_d, ph;
	logic [lrcts_pkg::ACC_W-1:0] minute_q, minute_d;
	logic [lrcts_pkg::ACC_W-1:0] second_q, second_d;
	logic [lrcts_pkg::ACC_W-1:0] frac_q, frac_d;
	logic [1:0] digits_q, digits_d;
	logic [lrcts_pkg::TIME_W-1:0] pending_q, pending_d;
	logic is_digit;
	logic [3:0] digit;
	logic [31:0] pending_ms;
	logic [7:0] b;

	assign b = item.text_byte;
	assign is_digit = (b >= lrcts_pkg::CH_ZERO) && (b <= lrcts_pkg::CH_NINE);
	assign digit = b[3:0];
	assign pending_ms = {{(32 - lrcts_pkg::TIME_W){1'b0}}, pending_q};

	always_comb begin
		// A restart clears the parse before the byte is handled.
		ph = item.restart ? lrcts_pkg::PH_BRACKET : phase_q;
		phase_d = ph;
		minute_d = minute_q;
		second_d = second_q;
		frac_d = frac_q;
		digits_d = digits_q;
		pending_d = pending_q;
		res.valid = 1'b0;
		res.ev = lrcts_pkg::EV_START;
		res.start_ms = pending_ms;
		res.char_out = 8'd0;

		if (ph > lrcts_pkg::PH_TEXT) begin
			phase_d = ph;
		end else if (item.text_end) begin
			res.valid = 1'b1;
			res.start_ms = '1;
			res.ev = (ph == lrcts_pkg::PH_FIRST) ? lrcts_pkg::EV_LYR_END
				: lrcts_pkg::EV_ERROR;
			phase_d = lrcts_pkg::PH_DONE;
		end else begin
			case (ph)
				lrcts_pkg::PH_BRACKET: begin
					if (b != lrcts_pkg::CH_LBRACKET) begin
						res.valid = 1'b1;
						res.ev = lrcts_pkg::EV_ERROR;
						res.start_ms = '1;
						phase_d = lrcts_pkg::PH_DONE;
					end else begin
						minute_d = '0;
						second_d = '0;
						frac_d = '0;
						digits_d = '0;
						phase_d = lrcts_pkg::PH_MIN;
					end
				end
				lrcts_pkg::PH_MIN: begin
					if (is_digit) begin
						minute_d = lrcts_pkg::sat_acc(minute_q, digit);
					end else begin
						phase_d = (b == lrcts_pkg::CH_COLON) ? lrcts_pkg::PH_SEC
							: lrcts_pkg::PH_SKIP_COL;
					end
				end
				lrcts_pkg::PH_SKIP_COL: begin
					if (b == lrcts_pkg::CH_COLON) phase_d = lrcts_pkg::PH_SEC;
				end
				lrcts_pkg::PH_SEC: begin
					if (is_digit) begin
						second_d = lrcts_pkg::sat_acc(second_q, digit);
					end else begin
						phase_d = (b == lrcts_pkg::CH_DOT) ? lrcts_pkg::PH_FRAC
							: lrcts_pkg::PH_SKIP_DOT;
					end
				end
				lrcts_pkg::PH_SKIP_DOT: begin
					if (b == lrcts_pkg::CH_DOT) phase_d = lrcts_pkg::PH_FRAC;
				end
				lrcts_pkg::PH_FRAC: begin
					if (is_digit) begin
						// Digits past the third are dropped, so the value stays below 1000.
						if (digits_q != 2'd3) begin
							frac_d = lrcts_pkg::ACC_W'(frac_q * 10'd10 + {6'd0, digit});
							digits_d = digits_q + 2'd1;
						end
					end else if (b == lrcts_pkg::CH_SPACE) begin
						pending_d = lrcts_pkg::line_time(minute_q, second_q, frac_q, digits_q);
						phase_d = lrcts_pkg::PH_FIRST;
					end else begin
						phase_d = lrcts_pkg::PH_SKIP_SPC;
					end
				end
				lrcts_pkg::PH_SKIP_SPC: begin
					if (b == lrcts_pkg::CH_SPACE) begin
						pending_d = lrcts_pkg::line_time(minute_q, second_q, frac_q, digits_q);
						phase_d = lrcts_pkg::PH_FIRST;
					end
				end
				lrcts_pkg::PH_FIRST: begin
					res.valid = 1'b1;
					if (b == lrcts_pkg::CH_NEWLINE) begin
						res.ev = lrcts_pkg::EV_EMPTY;
						phase_d = lrcts_pkg::PH_BRACKET;
					end else begin
						res.ev = lrcts_pkg::EV_START;
						res.char_out = b;
						phase_d = lrcts_pkg::PH_TEXT;
					end
				end
				lrcts_pkg::PH_TEXT: begin
					res.valid = 1'b1;
					if (b == lrcts_pkg::CH_NEWLINE) begin
						res.ev = lrcts_pkg::EV_LINE_END;
						phase_d = lrcts_pkg::PH_BRACKET;
					end else begin
						res.ev = lrcts_pkg::EV_TEXT;
						res.char_out = b;
					end
				end
				default: begin
					phase_d = lrcts_pkg::PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrcts_pkg::PH_BRACKET;
			minute_q <= '0;
			second_q <= '0;
			frac_q <= '0;
			digits_q <= '0;
			pending_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			minute_q <= minute_d;
			second_q <= second_d;
			frac_q <= frac_d;
			digits_q <= digits_d;
			pending_q <= pending_d;
		end
	end

`ifndef SYNTHESIS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == lrcts_pkg::PH_DONE && !item.restart) |=>
			(phase_q == lrcts_pkg::PH_DONE))
		else $error("parser left the done phase without a restart");

	a_minute_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(minute_q <= lrcts_pkg::FIELD_MAX) && (second_q <= lrcts_pkg::FIELD_MAX))
		else $error("time field accumulator above saturation limit");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(digits_q == 2'd0) |-> (frac_q == '0))
		else $error("fraction value present with no fraction digits");
`endif

endmodule

// ===== design/lrc_timestamp_parser_core.sv =====
// Top level of the lyric timestamp parser: input register, parser and output register.
// The parser takes one text byte per cycle and gives at most one event per byte; an event
// is carried from its byte through the input register and then the result register, and
// a byte that causes no event simply leaves nothing in the result register. A new byte is
// accepted every cycle unless a waiting event is stalled downstream, which is what sets the
// rate: one byte per clock while the output is not stalled, with a combinational parse step
// between the two registers.
module lrc_timestamp_parser_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] text_byte,
	input logic text_end,
	input logic restart,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] event_res,
	output logic [31:0] start_ms,
	output logic [7:0] char_out
);

	logic valid_s1;
	lrcts_pkg::item_t item_s1;
	logic advance;
	logic fire;
	lrcts_pkg::result_t res;
	logic out_valid_q;
	logic [2:0] event_q;
	logic [31:0] start_ms_q;
	logic [7:0] char_q;

	// The input register moves on whenever the result register can take a new transaction.
	assign advance = !(out_valid_q && out_stall);
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.text_byte <= text_byte;
			item_s1.text_end <= text_end;
			item_s1.restart <= restart;
		end
	end

	lrcts_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			event_q <= res.ev;
			start_ms_q <= res.start_ms;
			char_q <= res.char_out;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;
	assign start_ms = start_ms_q;
	assign char_out = char_q;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the result register is free");

	a_end_ms: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == lrcts_pkg::EV_LYR_END || event_res == lrcts_pkg::EV_ERROR))
			|-> (start_ms == 32'hFFFF_FFFF))
		else $error("terminal event without all-ones time");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res != lrcts_pkg::EV_START && event_res != lrcts_pkg::EV_TEXT)
			|-> (char_out == 8'd0))
		else $error("character present on an event without text");
`endif

endmodule
